// ===== rtl/core/pdr_pkg.sv =====
package pdr_pkg;

   localparam int TS_W            = 62;
   localparam int ID_W            = 64;
   localparam int PORT_W          = 16;
   localparam int SEQ_W           = 16;
   localparam int DELAY_W         = 63;
   localparam int DELAY_FRAC_BITS = 16;
   localparam int SMOOTH_W        = 17;
   localparam int SMOOTH_FRAC     = 16;
   localparam int STATUS_W        = 3;
   localparam int CSR_INDEX_W     = 8;
   localparam int CSR_DATA_W      = 64;
   localparam int REQ_W           = 456;
   localparam int MCAND_W         = 65;

   localparam logic [SMOOTH_W-1:0]    SMOOTH_ONE = 17'h10000;
   localparam logic [DELAY_W-1:0]     DELAY_MAX  = '1;

   localparam logic [CSR_INDEX_W-1:0] CSR_CLOCK_ID  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PORT_NUM  = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SMOOTHING = 8'd2;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 3'd0,
      STATUS_RESP_ID  = 3'd1,
      STATUS_RESP_SEQ = 3'd2,
      STATUS_FU_ID    = 3'd3,
      STATUS_FU_SEQ   = 3'd4,
      STATUS_TS_ORDER = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_PREP,
      ST_DIV,
      ST_MSTART,
      ST_MUL_RAW,
      ST_RAW,
      ST_SSTART,
      ST_MUL_AVG,
      ST_DONE
   } seq_state_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_SAT,
      DIV_RUN
   } div_state_type;

   // last field in the lowest bits
   typedef struct packed {
      logic [SEQ_W-1:0]  req_seq;
      logic [SEQ_W-1:0]  fu_seq;
      logic [PORT_W-1:0] fu_port;
      logic [ID_W-1:0]   fu_clock_id;
      logic [SEQ_W-1:0]  resp_seq;
      logic [PORT_W-1:0] resp_port;
      logic [ID_W-1:0]   resp_clock_id;
      logic [TS_W-1:0]   resp_rx_time;
      logic [TS_W-1:0]   resp_tx_time;
      logic [TS_W-1:0]   req_rx_time;
      logic [TS_W-1:0]   req_tx_time;
   } exchange_type;

endpackage

// ===== rtl/core/pdr_divider.sv =====
module pdr_divider #(
   parameter int QUOT_W = 42
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [pdr_pkg::TS_W-1:0]  num,
   input  logic [pdr_pkg::TS_W-1:0]  den,
   output logic                      done,
   output logic [QUOT_W-1:0]         quot
);
   import pdr_pkg::*;

   localparam int CNT_W = $clog2(QUOT_W + 1);

   div_state_type     state_ff, state_in;
   logic [TS_W-1:0]   num_ff, num_in;
   logic [TS_W-1:0]   den_ff, den_in;
   logic [TS_W-1:0]   rem_ff, rem_in;
   logic [1:0]        sh_ff, sh_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              done_ff, done_in;

   logic [TS_W:0]     trial;
   logic              trial_ge;
   logic [TS_W-1:0]   trial_rem;
   logic              sat;

   always_comb begin
      trial     = {rem_ff, sh_ff[1]};
      trial_ge  = trial >= {1'b0, den_ff};
      trial_rem = TS_W'(trial - {1'b0, den_ff});
      sat       = {2'b00, num_ff} >= {den_ff, 2'b00};
   end

   always_comb begin
      state_in = state_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      sh_in    = sh_ff;
      quot_in  = quot_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      case (state_ff)
         DIV_IDLE: begin
            if (start) begin
               num_in   = num;
               den_in   = den;
               state_in = DIV_SAT;
            end
         end
         DIV_SAT: begin
            if (sat) begin
               quot_in  = '1;
               done_in  = 1'b1;
               state_in = DIV_IDLE;
            end else begin
               rem_in   = num_ff >> 2;
               sh_in    = num_ff[1:0];
               quot_in  = '0;
               cnt_in   = CNT_W'(QUOT_W);
               state_in = DIV_RUN;
            end
         end
         DIV_RUN: begin
            sh_in   = {sh_ff[0], 1'b0};
            quot_in = {quot_ff[QUOT_W-2:0], trial_ge};
            rem_in  = trial_ge ? trial_rem : trial[TS_W-1:0];
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               done_in  = 1'b1;
               state_in = DIV_IDLE;
            end
         end
         default: begin
            state_in = DIV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      num_ff  <= num_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      sh_ff   <= sh_in;
      quot_ff <= quot_in;
      cnt_ff  <= cnt_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (state_ff == DIV_RUN) |-> (rem_ff < den_ff))
      else $error("divider remainder not below divisor");

endmodule

// ===== rtl/core/pdr_multiplier.sv =====
module pdr_multiplier #(
   parameter int MPLIER_W = 42
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   input  logic [pdr_pkg::MCAND_W-1:0]             mcand,
   input  logic [MPLIER_W-1:0]                     mplier,
   output logic                                    done,
   output logic [pdr_pkg::MCAND_W+MPLIER_W:0]      product
);
   import pdr_pkg::*;

   localparam int CNT_W = $clog2(MPLIER_W + 1);

   logic [MCAND_W-1:0]  mcand_ff, mcand_in;
   logic [MCAND_W:0]    hi_ff, hi_in;
   logic [MPLIER_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;

   logic [MCAND_W:0]    addend;
   logic [MCAND_W:0]    sum;

   // signed multiplicand, unsigned multiplier, one bit per cycle from the lsb
   always_comb begin
      addend = lo_ff[0] ? {mcand_ff[MCAND_W-1], mcand_ff} : '0;
      sum    = hi_ff + addend;
   end

   always_comb begin
      mcand_in = mcand_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (busy_ff) begin
         hi_in  = {sum[MCAND_W], sum[MCAND_W:1]};
         lo_in  = {sum[0], lo_ff[MPLIER_W-1:1]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         mcand_in = mcand;
         hi_in    = '0;
         lo_in    = mplier;
         cnt_in   = CNT_W'(MPLIER_W);
         busy_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      mcand_ff <= mcand_in;
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
      cnt_ff   <= cnt_in;
   end

   assign done    = done_ff;
   assign product = {hi_ff, lo_ff};

endmodule

// ===== rtl/core/peer_delay_rate_ratio_unit.sv =====
// channel | direction | handshake             | payload
// req     | in        | req_tvalid/req_tready | one peer-delay exchange (tdata)
// rsp     | out       | rsp_tvalid/rsp_tready | status, ratio, delay (tdata)
// csr     | in        | csr_valid/csr_ready   | csr_index, csr_data
//
// one item at a time; req_tready is high only between items
// accepted item: run time set by the bit-serial divider and up to two passes
// through the shared shift-add multiplier
// rejected item: from the check state straight to ST_DONE and the result register
// a finished result waits in the output register; the next item is taken meanwhile
// synchronous active-high reset; ratio resets to 1.0, smoothing factor to 1.0
module peer_delay_rate_ratio_unit #(
   parameter int RATIO_FRAC_BITS = 40
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // req_tx_time, req_rx_time, resp_tx_time, resp_rx_time, resp_clock_id,
   // resp_port, resp_seq, fu_clock_id, fu_port, fu_seq, req_seq
   input  logic [pdr_pkg::REQ_W-1:0]              req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // status, rate_ratio, ratio_updated, path_delay, delay_valid, zero pad
   output logic [((RATIO_FRAC_BITS + 77) / 8) * 8 - 1:0] rsp_tdata,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [pdr_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [pdr_pkg::CSR_DATA_W-1:0]         csr_data
);
   import pdr_pkg::*;

   localparam int RATIO_W = RATIO_FRAC_BITS + 2;
   localparam int RSP_W   = ((RATIO_FRAC_BITS + 77) / 8) * 8;
   localparam int PROD_W  = MCAND_W + RATIO_W + 1;
   localparam int SHIFT_R = RATIO_FRAC_BITS - DELAY_FRAC_BITS;
   localparam int A_W     = TS_W + RATIO_W - SHIFT_R;
   localparam logic [RATIO_W-1:0] RATIO_ONE = {2'b01, {RATIO_FRAC_BITS{1'b0}}};

   seq_state_type       state_ff, state_in;
   exchange_type        ex_ff, ex_in;

   logic [ID_W-1:0]     own_id_ff, own_id_in;
   logic [PORT_W-1:0]   own_port_ff, own_port_in;
   logic [SMOOTH_W-1:0] smooth_ff, smooth_in;

   logic [TS_W-1:0]     prev_tx_ff, prev_tx_in;
   logic [TS_W-1:0]     prev_rx_ff, prev_rx_in;
   logic                prev_valid_ff, prev_valid_in;
   logic [RATIO_W-1:0]  ratio_ff, ratio_in;
   logic [DELAY_W-1:0]  delay_ff, delay_in;
   logic                delay_seen_ff, delay_seen_in;

   status_type          status_ff, status_in;
   logic                updated_ff, updated_in;
   logic [TS_W-1:0]     d41_ff, d41_in;
   logic [TS_W-1:0]     d32_ff, d32_in;
   logic [DELAY_W-1:0]  raw_ff, raw_in;

   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [RATIO_W-1:0]  rsp_ratio_ff, rsp_ratio_in;
   logic                rsp_updated_ff, rsp_updated_in;
   logic [DELAY_W-1:0]  rsp_delay_ff, rsp_delay_in;
   logic                rsp_seen_ff, rsp_seen_in;

   logic                div_start;
   logic [TS_W-1:0]     div_num;
   logic [TS_W-1:0]     div_den;
   logic                div_done;
   logic [RATIO_W-1:0]  div_quot;

   logic                mul_start;
   logic [MCAND_W-1:0]  mul_mcand;
   logic [RATIO_W-1:0]  mul_mplier;
   logic                mul_done;
   logic [PROD_W-1:0]   mul_product;

   logic [A_W-1:0]      prod_a;
   logic [A_W-1:0]      prod_b;
   logic [A_W-1:0]      diff_ab;
   logic                a_gt_b;
   logic [DELAY_W-1:0]  raw_calc;
   logic [DELAY_W:0]    avg_diff;
   logic [DELAY_W:0]    avg_step;
   logic [SMOOTH_W-1:0] smooth_eff;

   pdr_divider #(
      .QUOT_W (RATIO_W)
   ) u_divider (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (div_num),
      .den    (div_den),
      .done   (div_done),
      .quot   (div_quot)
   );

   pdr_multiplier #(
      .MPLIER_W (RATIO_W)
   ) u_multiplier (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_mcand),
      .mplier  (mul_mplier),
      .done    (mul_done),
      .product (mul_product)
   );

   assign div_num   = ex_ff.resp_tx_time - prev_tx_ff;
   assign div_den   = ex_ff.resp_rx_time - prev_rx_ff;
   assign csr_ready = 1'b1;

   // raw delay from ratio * (t4 - t1) and t3 - t2
   always_comb begin
      prod_a  = mul_product[TS_W+RATIO_W-1:SHIFT_R];
      prod_b  = A_W'({d32_ff, {DELAY_FRAC_BITS{1'b0}}});
      a_gt_b  = prod_a > prod_b;
      diff_ab = prod_a - prod_b;
      if (!a_gt_b) begin
         raw_calc = '0;
      end else if (|diff_ab[A_W-1:DELAY_W+1]) begin
         raw_calc = DELAY_MAX;
      end else begin
         raw_calc = diff_ab[DELAY_W:1];
      end
      smooth_eff = (smooth_ff > SMOOTH_ONE) ? SMOOTH_ONE : smooth_ff;
      avg_diff   = {1'b0, raw_ff} - {1'b0, delay_ff};
      avg_step   = mul_product[SMOOTH_FRAC+DELAY_W:SMOOTH_FRAC];
   end

   always_comb begin
      own_id_in   = own_id_ff;
      own_port_in = own_port_ff;
      smooth_in   = smooth_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_CLOCK_ID:  own_id_in   = csr_data;
            CSR_PORT_NUM:  own_port_in = csr_data[PORT_W-1:0];
            CSR_SMOOTHING: smooth_in   = csr_data[SMOOTH_W-1:0];
            default:       own_id_in   = own_id_ff;
         endcase
      end
   end

   always_comb begin
      state_in       = state_ff;
      ex_in          = ex_ff;
      prev_tx_in     = prev_tx_ff;
      prev_rx_in     = prev_rx_ff;
      prev_valid_in  = prev_valid_ff;
      ratio_in       = ratio_ff;
      delay_in       = delay_ff;
      delay_seen_in  = delay_seen_ff;
      status_in      = status_ff;
      updated_in     = updated_ff;
      d41_in         = d41_ff;
      d32_in         = d32_ff;
      raw_in         = raw_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_ratio_in   = rsp_ratio_ff;
      rsp_updated_in = rsp_updated_ff;
      rsp_delay_in   = rsp_delay_ff;
      rsp_seen_in    = rsp_seen_ff;
      req_tready     = 1'b0;
      div_start      = 1'b0;
      mul_start      = 1'b0;
      mul_mcand      = '0;
      mul_mplier     = '0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ex_in    = exchange_type'(req_tdata);
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            updated_in = 1'b0;
            d41_in     = ex_ff.resp_rx_time - ex_ff.req_tx_time;
            d32_in     = ex_ff.resp_tx_time - ex_ff.req_rx_time;
            if (ex_ff.resp_clock_id != own_id_ff || ex_ff.resp_port != own_port_ff) begin
               status_in = STATUS_RESP_ID;
            end else if (ex_ff.resp_seq != ex_ff.req_seq) begin
               status_in = STATUS_RESP_SEQ;
            end else if (ex_ff.fu_clock_id != own_id_ff || ex_ff.fu_port != own_port_ff) begin
               status_in = STATUS_FU_ID;
            end else if (ex_ff.fu_seq != ex_ff.req_seq) begin
               status_in = STATUS_FU_SEQ;
            end else if (ex_ff.resp_rx_time < ex_ff.req_tx_time ||
                         ex_ff.resp_tx_time < ex_ff.req_rx_time) begin
               status_in = STATUS_TS_ORDER;
            end else begin
               status_in = STATUS_OK;
            end
            state_in = (status_in == STATUS_OK) ? ST_PREP : ST_DONE;
         end
         ST_PREP: begin
            prev_tx_in    = ex_ff.resp_tx_time;
            prev_rx_in    = ex_ff.resp_rx_time;
            prev_valid_in = 1'b1;
            if (prev_valid_ff && ex_ff.resp_rx_time > prev_rx_ff &&
                ex_ff.resp_tx_time >= prev_tx_ff) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else begin
               state_in = ST_MSTART;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               ratio_in   = div_quot;
               updated_in = 1'b1;
               state_in   = ST_MSTART;
            end
         end
         ST_MSTART: begin
            mul_start  = 1'b1;
            mul_mcand  = MCAND_W'(d41_ff);
            mul_mplier = ratio_ff;
            state_in   = ST_MUL_RAW;
         end
         ST_MUL_RAW: begin
            if (mul_done) begin
               state_in = ST_RAW;
            end
         end
         ST_RAW: begin
            raw_in = raw_calc;
            if (delay_seen_ff) begin
               state_in = ST_SSTART;
            end else begin
               delay_in      = raw_calc;
               delay_seen_in = 1'b1;
               state_in      = ST_DONE;
            end
         end
         ST_SSTART: begin
            mul_start  = 1'b1;
            mul_mcand  = {avg_diff[DELAY_W], avg_diff};
            mul_mplier = RATIO_W'(smooth_eff);
            state_in   = ST_MUL_AVG;
         end
         ST_MUL_AVG: begin
            // delay + floor(s * (raw - delay) / 2^16)
            if (mul_done) begin
               delay_in = DELAY_W'({1'b0, delay_ff} + avg_step);
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_ratio_in   = ratio_ff;
               rsp_updated_in = updated_ff;
               rsp_delay_in   = delay_ff;
               rsp_seen_in    = delay_seen_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         own_id_ff     <= '0;
         own_port_ff   <= '0;
         smooth_ff     <= SMOOTH_ONE;
         prev_tx_ff    <= '0;
         prev_rx_ff    <= '0;
         prev_valid_ff <= 1'b0;
         ratio_ff      <= RATIO_ONE;
         delay_ff      <= '0;
         delay_seen_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         own_id_ff     <= own_id_in;
         own_port_ff   <= own_port_in;
         smooth_ff     <= smooth_in;
         prev_tx_ff    <= prev_tx_in;
         prev_rx_ff    <= prev_rx_in;
         prev_valid_ff <= prev_valid_in;
         ratio_ff      <= ratio_in;
         delay_ff      <= delay_in;
         delay_seen_ff <= delay_seen_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      ex_ff          <= ex_in;
      status_ff      <= status_in;
      updated_ff     <= updated_in;
      d41_ff         <= d41_in;
      d32_ff         <= d32_in;
      raw_ff         <= raw_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_ratio_ff   <= rsp_ratio_in;
      rsp_updated_ff <= rsp_updated_in;
      rsp_delay_ff   <= rsp_delay_in;
      rsp_seen_ff    <= rsp_seen_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_seen_ff, rsp_delay_ff, rsp_updated_ff, rsp_ratio_ff,
                               rsp_status_ff});

   a_accept_starts_check: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_CHECK))
      else $error("accepted item did not start the check");

   a_mul_done_waited: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == ST_MUL_RAW || state_ff == ST_MUL_AVG))
      else $error("multiplier finished while sequencer not waiting");

   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished while sequencer not waiting");

   a_reject_no_update: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != STATUS_OK) |-> !rsp_updated_ff)
      else $error("rejected item reports a ratio update");

   a_prev_only_in_prep: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_PREP) |=> $stable(prev_valid_ff))
      else $error("previous timestamps changed outside an accepted item");

endmodule

// ===== tb/peer_delay_checker.sv =====
`timescale 1ns / 1ps

module peer_delay_checker #(
   parameter int RATIO_FRAC_BITS = 40
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_tvalid,
   input  logic                                          req_tready,
   input  logic [pdr_pkg::REQ_W-1:0]                     req_tdata,
   input  logic                                          rsp_tvalid,
   input  logic                                          rsp_tready,
   input  logic [((RATIO_FRAC_BITS + 77) / 8) * 8 - 1:0] rsp_tdata,
   input  logic                                          csr_valid,
   input  logic                                          csr_ready,
   input  logic [pdr_pkg::CSR_INDEX_W-1:0]               csr_index,
   input  logic [pdr_pkg::CSR_DATA_W-1:0]                csr_data,
   output int                                            errors,
   output int                                            pending,
   output int                                            exchanges_ok,
   output int                                            exchanges_rejected,
   output int                                            ratio_updates
);
   import pdr_pkg::*;

   localparam int RW = RATIO_FRAC_BITS + 2;
   localparam logic [RW-1:0] RATIO_ONE = {2'b01, {RATIO_FRAC_BITS{1'b0}}};
   localparam logic [RW-1:0] RATIO_TOP = '1;

   typedef struct packed {
      logic               delay_valid;
      logic [DELAY_W-1:0] path_delay;
      logic               ratio_updated;
      logic [RW-1:0]      rate_ratio;
      status_type         status;
   } result_type;

   localparam int RES_W = $bits(result_type);

   logic [ID_W-1:0]     cfg_clock_id;
   logic [PORT_W-1:0]   cfg_port_num;
   logic [SMOOTH_W-1:0] cfg_smooth;

   logic [TS_W-1:0]    last_t3;
   logic [TS_W-1:0]    last_t4;
   logic               have_prev;
   logic [RW-1:0]      ratio_q;
   logic [DELAY_W-1:0] delay_q;
   logic               delay_seen;

   result_type want_q[$];
   result_type want;
   result_type seen;
   int fails;
   int n_ok;
   int n_rej;
   int n_upd;
   int n_seen;

   function automatic logic [DELAY_W-1:0] clip_delay(input logic [127:0] v);
      return (v > 128'(DELAY_MAX)) ? DELAY_MAX : v[DELAY_W-1:0];
   endfunction

   function automatic result_type predict_exchange(input exchange_type ex);
      result_type r;
      status_type st;
      logic upd;
      logic [TS_W-1:0] dn, dd, fly, turn;
      logic [127:0] quo, scaled, lag, blend;
      logic [DELAY_W-1:0] raw;
      logic [SMOOTH_W-1:0] wt;
      upd = 1'b0;
      if (ex.resp_clock_id != cfg_clock_id || ex.resp_port != cfg_port_num)
         st = STATUS_RESP_ID;
      else if (ex.resp_seq != ex.req_seq)
         st = STATUS_RESP_SEQ;
      else if (ex.fu_clock_id != cfg_clock_id || ex.fu_port != cfg_port_num)
         st = STATUS_FU_ID;
      else if (ex.fu_seq != ex.req_seq)
         st = STATUS_FU_SEQ;
      else if (ex.resp_rx_time < ex.req_tx_time || ex.resp_tx_time < ex.req_rx_time)
         st = STATUS_TS_ORDER;
      else
         st = STATUS_OK;

      if (st == STATUS_OK) begin
         if (have_prev && ex.resp_rx_time > last_t4 && ex.resp_tx_time >= last_t3) begin
            dn = ex.resp_tx_time - last_t3;
            dd = ex.resp_rx_time - last_t4;
            quo = (128'(dn) << RATIO_FRAC_BITS) / 128'(dd);
            ratio_q = (quo > 128'(RATIO_TOP)) ? RATIO_TOP : quo[RW-1:0];
            upd = 1'b1;
         end
         last_t3 = ex.resp_tx_time;
         last_t4 = ex.resp_rx_time;
         have_prev = 1'b1;

         fly = ex.resp_rx_time - ex.req_tx_time;
         turn = ex.resp_tx_time - ex.req_rx_time;
         scaled = (128'(ratio_q) * 128'(fly)) >> (RATIO_FRAC_BITS - DELAY_FRAC_BITS);
         lag = 128'(turn) << DELAY_FRAC_BITS;
         if (scaled <= lag)
            raw = '0;
         else
            raw = clip_delay((scaled - lag) >> 1);

         if (!delay_seen) begin
            delay_q = raw;
         end else begin
            wt = (cfg_smooth > SMOOTH_ONE) ? SMOOTH_ONE : cfg_smooth;
            blend = (128'(wt) * 128'(raw) + 128'(SMOOTH_ONE - wt) * 128'(delay_q))
                    >> SMOOTH_FRAC;
            delay_q = clip_delay(blend);
         end
         delay_seen = 1'b1;
         n_ok++;
      end else begin
         n_rej++;
      end
      if (upd)
         n_upd++;

      r.status = st;
      r.rate_ratio = ratio_q;
      r.ratio_updated = upd;
      r.path_delay = delay_q;
      r.delay_valid = delay_seen;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg_clock_id = '0;
         cfg_port_num = '0;
         cfg_smooth = SMOOTH_ONE;
         last_t3 = '0;
         last_t4 = '0;
         have_prev = 1'b0;
         ratio_q = RATIO_ONE;
         delay_q = '0;
         delay_seen = 1'b0;
         want_q.delete();
         fails = 0;
         n_ok = 0;
         n_rej = 0;
         n_upd = 0;
         n_seen = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_tdata[RES_W-1:0];
            if (want_q.size() == 0) begin
               if (fails < 10)
                  $display("unexpected result %0d: %h", n_seen, seen);
               fails++;
            end else begin
               want = want_q.pop_front();
               if (seen.status !== want.status || seen.rate_ratio !== want.rate_ratio ||
                   seen.ratio_updated !== want.ratio_updated ||
                   seen.path_delay !== want.path_delay ||
                   seen.delay_valid !== want.delay_valid) begin
                  if (fails < 10)
                     $display({"result %0d expected/actual: status %0d/%0d ratio %h/%h",
                               " upd %0d/%0d delay %h/%h valid %0d/%0d"},
                              n_seen, want.status, seen.status, want.rate_ratio,
                              seen.rate_ratio, want.ratio_updated, seen.ratio_updated,
                              want.path_delay, seen.path_delay, want.delay_valid,
                              seen.delay_valid);
                  fails++;
               end
            end
            n_seen++;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CLOCK_ID:  cfg_clock_id = csr_data;
               CSR_PORT_NUM:  cfg_port_num = csr_data[PORT_W-1:0];
               CSR_SMOOTHING: cfg_smooth = csr_data[SMOOTH_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            want_q.push_back(predict_exchange(req_tdata));
      end
      errors <= fails;
      pending <= want_q.size();
      exchanges_ok <= n_ok;
      exchanges_rejected <= n_rej;
      ratio_updates <= n_upd;
   end

endmodule

// ===== tb/peer_delay_rate_ratio_unit_tb.sv =====
`timescale 1ns / 1ps

module peer_delay_rate_ratio_unit_tb;
   import pdr_pkg::*;

   localparam int RATIO_FRAC_BITS = 40;
   localparam int RSP_W = ((RATIO_FRAC_BITS + 77) / 8) * 8;
   localparam int LIMIT = 1_000_000;
   localparam int PHASE_ITEMS = 158;
   localparam logic [TS_W-1:0] TS_TOP = '1;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_W-1:0]       req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_W-1:0]       rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   int errors;
   int pending;
   int exchanges_ok;
   int exchanges_rejected;
   int ratio_updates;

   int  cycles = 0;
   logic steady = 1'b0;
   int  choke_req = 0;
   int  choke_ack = 0;
   int  choke_left = 0;
   int  settings = 0;

   logic [ID_W-1:0]   cfg_clock_id = '0;
   logic [PORT_W-1:0] cfg_port_num = '0;
   logic [SEQ_W-1:0]  seq_num = 16'hfffe;
   logic [TS_W-1:0]   local_ts = '0;
   logic [TS_W-1:0]   peer_ts = '0;

   peer_delay_rate_ratio_unit #(
      .RATIO_FRAC_BITS(RATIO_FRAC_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   peer_delay_checker #(
      .RATIO_FRAC_BITS(RATIO_FRAC_BITS)
   ) check (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .errors(errors),
      .pending(pending),
      .exchanges_ok(exchanges_ok),
      .exchanges_rejected(exchanges_rejected),
      .ratio_updates(ratio_updates)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // result side: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (choke_left > 0) begin
         rsp_tready <= 1'b0;
         choke_left <= choke_left - 1;
      end else if (choke_ack != choke_req) begin
         rsp_tready <= 1'b0;
         choke_ack <= choke_req;
         choke_left <= 3000;
      end else begin
         rsp_tready <= steady || ($urandom_range(0, 99) >= 24);
      end
   end

   function automatic logic [TS_W-1:0] rand_ts();
      logic [63:0] w;
      w = {$urandom(), $urandom()};
      return w[TS_W-1:0];
   endfunction

   function automatic logic [ID_W-1:0] rand_id();
      return {$urandom(), $urandom()};
   endfunction

   function automatic exchange_type good_exchange(input logic [TS_W-1:0] t1, t2, t3, t4);
      exchange_type ex;
      ex.req_tx_time = t1;
      ex.req_rx_time = t2;
      ex.resp_tx_time = t3;
      ex.resp_rx_time = t4;
      ex.resp_clock_id = cfg_clock_id;
      ex.resp_port = cfg_port_num;
      ex.resp_seq = seq_num;
      ex.fu_clock_id = cfg_clock_id;
      ex.fu_port = cfg_port_num;
      ex.fu_seq = seq_num;
      ex.req_seq = seq_num;
      seq_num = seq_num + 1'b1;
      return ex;
   endfunction

   // next exchange of a running link: both clocks advance, small drift
   function automatic exchange_type next_exchange();
      logic [TS_W-1:0] gap, path, turn, t4;
      case ($urandom_range(0, 19))
         0:       gap = '0;
         1:       gap = rand_ts();
         default: gap = TS_W'($urandom_range(1, 1_000_000_000));
      endcase
      local_ts = local_ts + gap;
      peer_ts = peer_ts + gap + TS_W'($urandom_range(0, 2000)) - TS_W'(1000);
      path = TS_W'($urandom_range(0, 100_000));
      turn = TS_W'($urandom_range(0, 1_000_000));
      t4 = local_ts + path + path + turn + TS_W'($urandom_range(0, 200)) - TS_W'(100);
      return good_exchange(local_ts, peer_ts + path, peer_ts + path + turn, t4);
   endfunction

   function automatic exchange_type break_exchange(input exchange_type ex,
                                                   input status_type fault);
      case (fault)
         STATUS_RESP_ID: begin
            if ($urandom_range(0, 1))
               ex.resp_clock_id = ex.resp_clock_id ^ (rand_id() | 64'd1);
            else
               ex.resp_port = ex.resp_port ^ (16'($urandom()) | 16'h8000);
         end
         STATUS_RESP_SEQ: ex.resp_seq = ex.resp_seq ^ (16'($urandom()) | 16'd1);
         STATUS_FU_ID: begin
            if ($urandom_range(0, 1))
               ex.fu_clock_id = ex.fu_clock_id ^ (rand_id() | 64'h8000_0000_0000_0000);
            else
               ex.fu_port = ex.fu_port ^ (16'($urandom()) | 16'd1);
         end
         STATUS_FU_SEQ: ex.fu_seq = ex.fu_seq ^ (16'($urandom()) | 16'h8000);
         default: begin
            if ($urandom_range(0, 1)) begin
               if (ex.req_tx_time < 1000)
                  ex.req_tx_time = ex.req_tx_time + 1000;
               ex.resp_rx_time = ex.req_tx_time - TS_W'($urandom_range(1, 1000));
            end else begin
               if (ex.req_rx_time < 1000)
                  ex.req_rx_time = ex.req_rx_time + 1000;
               ex.resp_tx_time = ex.req_rx_time - TS_W'($urandom_range(1, 1000));
            end
         end
      endcase
      return ex;
   endfunction

   function automatic exchange_type random_exchange();
      logic [TS_W-1:0] a, b, c, d;
      logic [479:0] bits;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         local_ts = rand_ts();
         peer_ts = rand_ts();
      end
      if (pick < 70)
         return next_exchange();
      if (pick < 80) begin
         a = rand_ts();
         b = rand_ts();
         c = rand_ts();
         d = rand_ts();
         return good_exchange(a < b ? a : b, c < d ? c : d, c < d ? d : c, a < b ? b : a);
      end
      if (pick < 95)
         return break_exchange(next_exchange(), status_type'($urandom_range(1, 5)));
      for (int k = 0; k < 15; k++)
         bits[k*32 +: 32] = $urandom();
      return exchange_type'(bits[REQ_W-1:0]);
   endfunction

   task automatic send_exchange(input exchange_type ex);
      while (!steady && $urandom_range(0, 99) < 24) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= ex;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(input logic [ID_W-1:0] id, input logic [PORT_W-1:0] port,
                             input logic [SMOOTH_W-1:0] weight);
      wait_idle();
      write_csr(CSR_CLOCK_ID, id);
      write_csr(CSR_PORT_NUM, CSR_DATA_W'(port));
      write_csr(CSR_SMOOTHING, CSR_DATA_W'(weight));
      cfg_clock_id = id;
      cfg_port_num = port;
      seq_num = 16'($urandom());
      settings++;
   endtask

   task automatic random_run(input int count);
      for (int i = 0; i < count; i++)
         send_exchange(random_exchange());
   endtask

   initial begin
      exchange_type ex;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values of the identity registers
      send_exchange(good_exchange('0, '0, '0, '0));
      send_exchange(good_exchange('0, 62'd5, 62'd10, '0));
      send_exchange(good_exchange(62'd1000, 62'd500, 62'd600, 62'd1300));
      ex = good_exchange(62'd1500, 62'd700, 62'd800, 62'd1900);
      ex.resp_clock_id = ~ex.resp_clock_id;
      send_exchange(ex);
      ex = good_exchange(62'd1500, 62'd700, 62'd800, 62'd1900);
      ex.resp_port = ex.resp_port ^ 16'h8000;
      send_exchange(ex);
      ex = good_exchange(62'd1500, 62'd700, 62'd800, 62'd1900);
      ex.resp_seq = ~ex.resp_seq;
      send_exchange(ex);
      ex = good_exchange(62'd1500, 62'd700, 62'd800, 62'd1900);
      ex.fu_clock_id = 64'd1;
      send_exchange(ex);
      ex = good_exchange(62'd1500, 62'd700, 62'd800, 62'd1900);
      ex.fu_port = 16'hffff;
      send_exchange(ex);
      ex = good_exchange(62'd1500, 62'd700, 62'd800, 62'd1900);
      ex.fu_seq = ex.fu_seq + 1'b1;
      send_exchange(ex);
      send_exchange(good_exchange(62'd2000, '0, '0, 62'd1999));
      send_exchange(good_exchange(62'd2000, 62'd10, 62'd9, 62'd3000));
      ex = good_exchange(62'd5, 62'd4, 62'd3, 62'd2);
      ex.resp_clock_id = 64'hffff_ffff_ffff_ffff;
      ex.resp_seq = ~ex.req_seq;
      ex.fu_port = 16'h1234;
      ex.fu_seq = ~ex.req_seq;
      send_exchange(ex);

      // all-ones identity, saturated ratio and delay, skipped ratios
      set_config(64'hffff_ffff_ffff_ffff, 16'hffff, SMOOTH_ONE);
      send_exchange(good_exchange('0, '0, TS_TOP, 62'd1400));
      send_exchange(good_exchange('0, '0, '0, TS_TOP));
      send_exchange(good_exchange(62'd100, 62'd200, 62'd300, 62'd500));
      send_exchange(good_exchange(62'd1000, 62'd1000, 62'd2000, 62'd2100));
      send_exchange(good_exchange(62'd3000, 62'd3000, 62'd3000, 62'd3000));
      send_exchange(good_exchange(rand_ts() >> 1, 62'd0, rand_ts(), TS_TOP));

      local_ts = 62'd4000;
      peer_ts = 62'd4000;
      set_config(rand_id(), 16'($urandom()), 17'd0);
      random_run(PHASE_ITEMS);
      set_config('0, '0, 17'd1);
      random_run(PHASE_ITEMS);
      set_config(64'hffff_ffff_ffff_ffff, 16'hffff, 17'hffff);
      random_run(PHASE_ITEMS);
      set_config(rand_id(), 16'($urandom()), 17'h8000);
      steady <= 1'b1;
      random_run(PHASE_ITEMS);
      wait_idle();
      steady <= 1'b0;
      set_config(rand_id(), 16'($urandom()), SMOOTH_ONE);
      choke_req <= choke_req + 1;
      random_run(PHASE_ITEMS);
      set_config(rand_id(), 16'($urandom()), 17'($urandom_range(0, 65536)));
      random_run(PHASE_ITEMS);

      wait_idle();
      repeat (160) @(posedge clock);
      $display("%0d exchanges checked: %0d accepted, %0d rejected, %0d rate ratio updates",
               exchanges_ok + exchanges_rejected, exchanges_ok, exchanges_rejected,
               ratio_updates);
      $display("%0d register settings, smoothing weights 0 to 1.0, stalls and back-pressure",
               settings + 1);
      if (errors == 0 && pending == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
